### rtl/core/i2c_ram_pkg.sv
// Shared types and constants for the I2C register-access master.
// Holds the segment program table, opcodes, status codes and result record.
// No dependencies.
package i2c_ram_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_PROBE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SEG_NONE      = 4'd0,
    SEG_START     = 4'd1,
    SEG_SEND_AW   = 4'd2,
    SEG_SEND_REG  = 4'd3,
    SEG_SEND_DATA = 4'd4,
    SEG_SEND_AR   = 4'd5,
    SEG_ACK       = 4'd6,
    SEG_READ      = 4'd7,
    SEG_NACK      = 4'd8,
    SEG_STOP      = 4'd9
  } seg_e;

  localparam logic [1:0] ST_ACK      = 2'd0;
  localparam logic [1:0] ST_NACK     = 2'd1;
  localparam logic [1:0] ST_BUS_BUSY = 2'd2;

  localparam logic [15:0] PHASE_LEN_RESET = 16'd250;

  localparam int unsigned StepW = 6;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       listen;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] rdata;
  } res_t;

  // Segment program: which bus segment runs at each step of each opcode.
  function automatic seg_e seg_of(op_e op, logic [StepW-1:0] step);
    seg_e s;
    s = SEG_NONE;
    unique case (op)
      OP_WRITE: begin
        unique case (step)
          6'd1:    s = SEG_START;
          6'd2:    s = SEG_SEND_AW;
          6'd3:    s = SEG_ACK;
          6'd4:    s = SEG_SEND_REG;
          6'd5:    s = SEG_ACK;
          6'd6:    s = SEG_SEND_DATA;
          6'd7:    s = SEG_ACK;
          6'd8:    s = SEG_STOP;
          default: s = SEG_NONE;
        endcase
      end
      OP_READ: begin
        unique case (step)
          6'd1:    s = SEG_START;
          6'd2:    s = SEG_SEND_AW;
          6'd3:    s = SEG_ACK;
          6'd4:    s = SEG_SEND_REG;
          6'd5:    s = SEG_ACK;
          6'd6:    s = SEG_START;
          6'd7:    s = SEG_SEND_AR;
          6'd8:    s = SEG_ACK;
          6'd9:    s = SEG_READ;
          6'd10:   s = SEG_NACK;
          6'd11:   s = SEG_STOP;
          default: s = SEG_NONE;
        endcase
      end
      OP_PROBE: begin
        unique case (step)
          6'd1:    s = SEG_START;
          6'd2:    s = SEG_SEND_AW;
          6'd3:    s = SEG_ACK;
          6'd4:    s = SEG_STOP;
          default: s = SEG_NONE;
        endcase
      end
      default: s = SEG_NONE;
    endcase
    return s;
  endfunction

  // Step of the stop segment, used to bail out after a NACK.
  function automatic logic [StepW-1:0] stop_step(op_e op);
    logic [StepW-1:0] s;
    unique case (op)
      OP_WRITE: s = 6'd8;
      OP_READ:  s = 6'd11;
      OP_PROBE: s = 6'd4;
      default:  s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/i2c_register_access_master_unit.sv
// I2C register-access master, open-drain bit sequencer.
// Input channel (in_valid_i/in_ready_o): each transfer is a tick (opcode 0) or a
// command: write register, read register or probe device. A command starts a
// transaction only when idle; while busy every transfer counts as a tick.
// Ticks pace the bus: each bus phase lasts phase_length ticks (reset value 250).
// User writes it via cfg_we_i/cfg_wdata_i while the block is idle; not enforced.
// Output channel (out_valid_o/out_ready_i): exactly one result per input
// transfer with the SCL/SDA drive to apply, sda_listen, busy, done, status and
// the last read byte. sda_sense_i/scl_sense_i are sampled on every transfer.
// The result is registered and is valid in the cycle after acceptance.
// Throughput is one transfer per cycle while results are taken, set by the
// single result register behind the next-state logic. When the receiver stalls,
// the result is held and in_ready_o drops until it is taken.
// Reset clears the sequencer to idle with both lines released, status 0 and
// read data 0; the first result follows the first accepted transfer.
// Depends on i2c_ram_pkg, i2c_ram_core and i2c_ram_out.
module i2c_register_access_master_unit import i2c_ram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [6:0]  device_address_i,
  input  logic [7:0]  register_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_sense_i,
  input  logic        scl_sense_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_level_o,
  output logic        sda_listen_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [7:0]  read_data_o
);

  res_t res_next, res_held;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  i2c_ram_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .accept_i           (accept),
    .opcode_i           (opcode_i),
    .device_address_i   (device_address_i),
    .register_address_i (register_address_i),
    .write_data_i       (write_data_i),
    .sda_sense_i        (sda_sense_i),
    .scl_sense_i        (scl_sense_i),
    .res_o              (res_next)
  );

  i2c_ram_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (res_next),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_held)
  );

  assign scl_level_o  = res_held.scl;
  assign sda_level_o  = res_held.sda;
  assign sda_listen_o = res_held.listen;
  assign busy_res_o   = res_held.busy;
  assign done_res_o   = res_held.done;
  assign status_o     = res_held.status;
  assign read_data_o  = res_held.rdata;

endmodule

### rtl/core/i2c_ram_core.sv
// Bus sequencer state and per-transfer next-state logic of the I2C master.
// Each accepted item updates all sequencer state. Depends on i2c_ram_pkg.
module i2c_ram_core import i2c_ram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [1:0]  opcode_i,
  input  logic [6:0]  device_address_i,
  input  logic [7:0]  register_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_sense_i,
  input  logic        scl_sense_i,
  output res_t        res_o
);

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [7:0]       shift;
  } entry_t;

  logic [15:0]      plen_q;
  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       sub_q, sub_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [15:0]      pc_q, pc_d;
  op_e              op_q, op_d;
  logic [6:0]       dev_q, dev_d;
  logic [7:0]       reg_q, reg_d;
  logic [7:0]       dat_q, dat_d;
  logic [1:0]       status_q, status_d;
  logic [7:0]       rdata_q, rdata_d;

  logic [15:0] pc_inc, limit;
  logic [1:0]  ack_status;
  logic        done;
  seg_e        seg_q, seg_d;
  entry_t      ent;
  logic [1:0]  drive;
  logic        listen;
  op_e         in_op;

  assign in_op = op_e'(opcode_i);

  // Loads the next segment; bytes to send are taken from the held command.
  function automatic entry_t enter_step(op_e op, logic [6:0] dev, logic [7:0] ra,
                                        logic [7:0] dat, logic [StepW-1:0] step,
                                        logic [7:0] shift_cur);
    entry_t r;
    r.step  = step;
    r.shift = shift_cur;
    case (seg_of(op, step))
      SEG_SEND_AW:   r.shift = {dev, 1'b0};
      SEG_SEND_AR:   r.shift = {dev, 1'b1};
      SEG_SEND_REG:  r.shift = ra;
      SEG_SEND_DATA: r.shift = dat;
      SEG_NONE:      r.step  = '0;
      default:       ;
    endcase
    return r;
  endfunction

  assign seg_q  = seg_of(op_q, step_q);
  assign pc_inc = pc_q + 16'd1;
  assign limit  = (plen_q == 16'd0) ? 16'd1 : plen_q;
  assign ack_status = (sub_q == 2'd1 && sda_sense_i) ? ST_NACK : status_q;

  always_comb begin
    step_d   = step_q;
    sub_d    = sub_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    pc_d     = pc_q;
    op_d     = op_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    dat_d    = dat_q;
    status_d = status_q;
    rdata_d  = rdata_q;
    done     = 1'b0;
    ent      = '0;

    if (step_q != '0) begin
      if (pc_inc >= limit) begin
        pc_d = '0;
        case (seg_q)
          SEG_START, SEG_NACK: begin
            if (sub_q < 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              ent     = enter_step(op_q, dev_q, reg_q, dat_q, step_q + 6'd1, shift_q);
              step_d  = ent.step;
              shift_d = ent.shift;
              sub_d   = '0;
              bit_d   = '0;
            end
          end
          SEG_SEND_AW, SEG_SEND_REG, SEG_SEND_DATA, SEG_SEND_AR: begin
            if (sub_q < 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else if (bit_q == 3'd7) begin
              ent     = enter_step(op_q, dev_q, reg_q, dat_q, step_q + 6'd1,
                                   {shift_q[6:0], 1'b0});
              step_d  = ent.step;
              shift_d = ent.shift;
              sub_d   = '0;
              bit_d   = '0;
            end else begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 3'd1;
              sub_d   = '0;
            end
          end
          SEG_ACK: begin
            status_d = ack_status;
            if (sub_q < 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              // NACK: jump straight to the stop segment
              if (ack_status == ST_NACK) begin
                if (op_q == OP_READ) rdata_d = '0;
                ent = enter_step(op_q, dev_q, reg_q, dat_q, stop_step(op_q), shift_q);
              end else begin
                ent = enter_step(op_q, dev_q, reg_q, dat_q, step_q + 6'd1, shift_q);
              end
              step_d  = ent.step;
              shift_d = ent.shift;
              sub_d   = '0;
              bit_d   = '0;
            end
          end
          SEG_READ: begin
            if (sub_q == 2'd0) begin
              shift_d = {shift_q[6:0], sda_sense_i};
              sub_d   = 2'd1;
            end else if (bit_q == 3'd7) begin
              rdata_d = shift_q;
              ent     = enter_step(op_q, dev_q, reg_q, dat_q, step_q + 6'd1, shift_q);
              step_d  = ent.step;
              shift_d = ent.shift;
              sub_d   = '0;
              bit_d   = '0;
            end else begin
              bit_d = bit_q + 3'd1;
              sub_d = '0;
            end
          end
          SEG_STOP: begin
            if (sub_q < 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              step_d = '0;
              sub_d  = '0;
              done   = 1'b1;
            end
          end
          default: begin
            step_d = '0;
            sub_d  = '0;
          end
        endcase
      end else begin
        pc_d = pc_inc;
      end
    end else if (in_op != OP_TICK) begin
      op_d  = in_op;
      dev_d = device_address_i;
      reg_d = register_address_i;
      dat_d = write_data_i;
      if (in_op == OP_PROBE && (!sda_sense_i || !scl_sense_i)) begin
        status_d = ST_BUS_BUSY;
        done     = 1'b1;
      end else begin
        status_d = ST_ACK;
        pc_d     = '0;
        ent      = enter_step(in_op, device_address_i, register_address_i,
                              write_data_i, 6'd1, shift_q);
        step_d   = ent.step;
        shift_d  = ent.shift;
        sub_d    = '0;
        bit_d    = '0;
      end
    end
  end

  // Line drive of the phase being entered: drive[1] SCL, drive[0] SDA.
  assign seg_d = seg_of(op_d, step_d);

  always_comb begin
    listen = 1'b0;
    drive  = 2'b11;
    case (seg_d)
      SEG_START: drive = (sub_d == 2'd0) ? 2'b11 : ((sub_d == 2'd1) ? 2'b10 : 2'b00);
      SEG_SEND_AW, SEG_SEND_REG, SEG_SEND_DATA, SEG_SEND_AR: begin
        if (sub_d == 2'd1)                          drive = {1'b1, shift_d[7]};
        else if (sub_d == 2'd2 && bit_d == 3'd7)    drive = 2'b01;
        else                                        drive = {1'b0, shift_d[7]};
      end
      SEG_ACK: begin
        listen = 1'b1;
        drive  = (sub_d == 2'd1) ? 2'b11 : 2'b01;
      end
      SEG_READ: begin
        listen = 1'b1;
        drive  = (sub_d == 2'd0) ? 2'b11 : 2'b01;
      end
      SEG_NACK: drive = (sub_d == 2'd1) ? 2'b11 : 2'b01;
      SEG_STOP: drive = (sub_d == 2'd0) ? 2'b00 : ((sub_d == 2'd1) ? 2'b10 : 2'b11);
      default:  drive = 2'b11;
    endcase
  end

  always_comb begin
    res_o.scl    = drive[1];
    res_o.sda    = drive[0];
    res_o.listen = listen;
    res_o.busy   = (step_d != '0);
    res_o.done   = done;
    res_o.status = status_d;
    res_o.rdata  = rdata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PHASE_LEN_RESET;
    end else if (cfg_we_i) begin
      plen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      sub_q    <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      pc_q     <= '0;
      op_q     <= OP_TICK;
      dev_q    <= '0;
      reg_q    <= '0;
      dat_q    <= '0;
      status_q <= ST_ACK;
      rdata_q  <= '0;
    end else if (accept_i) begin
      step_q   <= step_d;
      sub_q    <= sub_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      pc_q     <= pc_d;
      op_q     <= op_d;
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      dat_q    <= dat_d;
      status_q <= status_d;
      rdata_q  <= rdata_d;
    end
  end

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.done |-> !res_o.busy)
    else $error("transaction reported done while still busy");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> op_q != OP_TICK && seg_q != SEG_NONE)
    else $error("sequencer active without a valid segment");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && step_q == '0 && in_op == OP_TICK
      |-> res_o.scl && res_o.sda && !res_o.done && !res_o.busy)
    else $error("idle tick changed the bus or reported done");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && step_q != '0 && pc_inc < limit |=> step_q == $past(step_q)
      && sub_q == $past(sub_q))
    else $error("bus phase advanced before its length elapsed");

endmodule

### rtl/core/i2c_ram_out.sv
// Result register of the I2C master: holds one result until it is taken.
// Depends on i2c_ram_pkg for the result record.
module i2c_ram_out import i2c_ram_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  // A new transfer may enter when no result is held or the held one leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
